/* src/canflt_pkg.sv */
// Shared types and constants for the CAN receive acceptance filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package canflt_pkg;

  // Fixed sizes of the frame and of the bind register file
  localparam int unsigned ENTRY_COUNT = 8;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned ID_W        = 11;
  localparam int unsigned DLC_W       = 4;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned NBYTES      = 8;
  localparam int unsigned CFG_W       = 28;
  localparam logic [ID_W-1:0]  ID_MASK = 11'h7FF;
  localparam logic [DLC_W-1:0] MAX_LEN = 4'd8;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic {
    KIND_NOTIFY = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  // Bind entry register layout, most significant field first
  typedef struct packed {
    logic             notify;
    logic [DLC_W-1:0] copy_len;
    logic [ID_W-1:0]  mask;
    logic [ID_W-1:0]  id;
    logic             valid;
  } bind_t;

  // Classified request handed from front to back
  typedef struct packed {
    op_e                                op;
    logic [ID_W-1:0]                    id;
    logic [DLC_W-1:0]                   dlc;
    logic [DATA_W-1:0]                  data;
    logic [SLOT_W-1:0]                  rslot;
    logic [ENTRY_COUNT-1:0]             match;
    logic [ENTRY_COUNT-1:0]             notify;
    logic [ENTRY_COUNT-1:0][NBYTES-1:0] bmask;
  } item_t;

  // Queue status seen by the back end and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Clamp a length code to eight bytes
  function automatic logic [DLC_W-1:0] sat_len(input logic [DLC_W-1:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

endpackage

`default_nettype wire

/* src/canflt_front.sv */
// Front end: bind entry registers, request intake and match classification.
// Depends on canflt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module canflt_front #(
  parameter int unsigned NUM_BINDS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [canflt_pkg::SLOT_W-1:0]  cfg_idx_i,
  input  wire logic [canflt_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic                           op_i,
  input  wire logic [canflt_pkg::ID_W-1:0]    frame_id_i,
  input  wire logic [canflt_pkg::DLC_W-1:0]   frame_len_i,
  input  wire logic [canflt_pkg::DATA_W-1:0]  frame_data_i,
  input  wire logic [canflt_pkg::SLOT_W-1:0]  read_slot_i,
  output canflt_pkg::item_t                   item_o
);
  import canflt_pkg::*;

  bind_t            bind_q [NUM_BINDS];
  logic [DLC_W-1:0] dlc;

  // Write bind entries; indexes without an entry drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINDS; i++) begin
        bind_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_BINDS; i++) begin
        if (cfg_idx_i == SLOT_W'(i)) begin
          bind_q[i] <= bind_t'(cfg_wdata_i);
        end
      end
    end
  end

  assign dlc = sat_len(frame_len_i);

  // Classify the request against every entry in parallel
  always_comb begin
    logic [DLC_W-1:0] n;
    item_o        = '0;
    item_o.op     = op_e'(op_i);
    item_o.id     = frame_id_i & ID_MASK;
    item_o.dlc    = dlc;
    item_o.data   = frame_data_i;
    item_o.rslot  = read_slot_i;
    for (int i = 0; i < NUM_BINDS; i++) begin
      item_o.match[i]  = bind_q[i].valid &&
                         (((frame_id_i ^ bind_q[i].id) & bind_q[i].mask) == '0);
      item_o.notify[i] = bind_q[i].notify;
      n = (sat_len(bind_q[i].copy_len) < dlc) ? sat_len(bind_q[i].copy_len) : dlc;
      for (int b = 0; b < NBYTES; b++) begin
        item_o.bmask[i][b] = (DLC_W'(b) < n);
      end
    end
  end

endmodule

`default_nettype wire

/* src/canflt_queue.sv */
// Short request queue that decouples the front end from the back end.
// Depends on canflt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module canflt_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire canflt_pkg::item_t item_i,
  input  wire logic          pop_i,
  output canflt_pkg::item_t  head_o,
  output canflt_pkg::qstat_t stat_o
);
  import canflt_pkg::*;

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store request payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* src/canflt_back.sv */
// Back end: mailboxes, per-entry match sequencer and result register.
// Depends on canflt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module canflt_back #(
  parameter int unsigned NUM_BINDS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire canflt_pkg::item_t              head_i,
  input  wire logic                           q_empty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                kind_o,
  output logic [canflt_pkg::SLOT_W-1:0]       slot_o,
  output logic [canflt_pkg::ID_W-1:0]         out_id_o,
  output logic [canflt_pkg::DLC_W-1:0]        out_len_o,
  output logic [canflt_pkg::DATA_W-1:0]       out_data_o,
  output logic                                last_o
);
  import canflt_pkg::*;

  logic [DATA_W-1:0]      mbox_q [NUM_BINDS];
  item_t                  cur_q;
  logic                   busy_q, busy_d;
  logic [ENTRY_COUNT-1:0] pend_q, pend_d, sel, rest;
  logic [SLOT_W-1:0]      sel_idx;
  logic                   sel_notify, out_free;
  logic                   load_en, step_en, emit_en, done_en;
  logic [DATA_W-1:0]      rd_data;

  logic                   out_valid_q;
  kind_e                  kind_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [ID_W-1:0]        id_q;
  logic [DLC_W-1:0]       len_q;
  logic [DATA_W-1:0]      data_q;
  logic                   last_q;

  // Pick the lowest pending match
  assign sel        = pend_q & (~pend_q + 1'b1);
  assign rest       = pend_q & ~sel;
  assign sel_notify = |(sel & cur_q.notify);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    sel_idx = '0;
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_idx = SLOT_W'(i);
      end
    end
  end

  // Mailbox read port; slots without an entry read as zero
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < NUM_BINDS; i++) begin
      if (cur_q.rslot == SLOT_W'(i)) begin
        rd_data = mbox_q[i];
      end
    end
  end

  // Sequence one request: load, then one matching entry per step (a read: load, then emit)
  always_comb begin
    load_en = !busy_q && !q_empty_i;
    step_en = 1'b0;
    emit_en = 1'b0;
    done_en = 1'b0;
    if (busy_q) begin
      if (cur_q.op == OP_READ) begin
        emit_en = out_free;
        done_en = out_free;
      end else if (pend_q == '0) begin
        done_en = 1'b1;
      end else begin
        step_en = !sel_notify || out_free;
        emit_en = step_en && sel_notify;
      end
    end
    busy_d = busy_q;
    pend_d = pend_q;
    if (load_en) begin
      busy_d = 1'b1;
      pend_d = head_i.match;
    end else begin
      if (done_en) begin
        busy_d = 1'b0;
      end
      if (step_en) begin
        pend_d = rest;
      end
    end
  end

  assign pop_o = load_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the request being worked on
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      cur_q <= head_i;
    end
  end

  // Merge copied bytes into the selected mailbox
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BINDS; i++) begin
        mbox_q[i] <= '0;
      end
    end else if (step_en) begin
      for (int i = 0; i < NUM_BINDS; i++) begin
        if (sel[i]) begin
          for (int b = 0; b < NBYTES; b++) begin
            if (cur_q.bmask[i][b]) begin
              mbox_q[i][b*8 +: 8] <= cur_q.data[b*8 +: 8];
            end
          end
        end
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      if (cur_q.op == OP_READ) begin
        kind_q <= KIND_READ;
        slot_q <= cur_q.rslot;
        id_q   <= '0;
        len_q  <= '0;
        data_q <= rd_data;
        last_q <= 1'b1;
      end else begin
        kind_q <= KIND_NOTIFY;
        slot_q <= sel_idx;
        id_q   <= cur_q.id;
        len_q  <= cur_q.dlc;
        data_q <= cur_q.data;
        last_q <= ((rest & cur_q.notify) == '0);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign slot_o      = slot_q;
  assign out_id_o    = id_q;
  assign out_len_o   = len_q;
  assign out_data_o  = data_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

/* src/can_rx_id_mask_filter_mailbox.sv */
// CAN receive acceptance filter with per-entry mailboxes, top level.
// Requests enter every cycle while the two-deep queue has room. The back end loads a request,
// handles one matching entry per step and then closes it (a read: load, then emit), and
// takes the next one only once it is closed; output stalls hold it longer. Reset clears bind
// entries, mailboxes, queue pointers and the result valid flag at once.
`timescale 1ns / 1ps
`default_nettype none

module can_rx_id_mask_filter_mailbox #(
  parameter int unsigned NUM_BINDS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [canflt_pkg::SLOT_W-1:0]  cfg_idx_i,
  input  wire logic [canflt_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           op_i,
  input  wire logic [canflt_pkg::ID_W-1:0]    frame_id_i,
  input  wire logic [canflt_pkg::DLC_W-1:0]   frame_len_i,
  input  wire logic [canflt_pkg::DATA_W-1:0]  frame_data_i,
  input  wire logic [canflt_pkg::SLOT_W-1:0]  read_slot_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                kind_o,
  output logic [canflt_pkg::SLOT_W-1:0]       slot_o,
  output logic [canflt_pkg::ID_W-1:0]         out_id_o,
  output logic [canflt_pkg::DLC_W-1:0]        out_len_o,
  output logic [canflt_pkg::DATA_W-1:0]       out_data_o,
  output logic                                last_o
);
  import canflt_pkg::*;

  item_t  front_item, head;
  qstat_t qstat;
  logic   pop;

  canflt_front #(.NUM_BINDS(NUM_BINDS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_i         (op_i),
    .frame_id_i   (frame_id_i),
    .frame_len_i  (frame_len_i),
    .frame_data_i (frame_data_i),
    .read_slot_i  (read_slot_i),
    .item_o       (front_item)
  );

  canflt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .item_i (front_item),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  canflt_back #(.NUM_BINDS(NUM_BINDS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (qstat.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .slot_o      (slot_o),
    .out_id_o    (out_id_o),
    .out_len_o   (out_len_o),
    .out_data_o  (out_data_o),
    .last_o      (last_o)
  );

  // Hold off requests while the queue is full
  assign in_stall_o = qstat.full;

  // Queue cannot be full and empty at once
  a_q_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  // A mailbox read is a single, final result with no frame header
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_READ) |-> last_o && (out_id_o == '0) && (out_len_o == '0))
    else $error("mailbox read result malformed");

  // Notification lengths are saturated
  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_NOTIFY) |-> (out_len_o <= MAX_LEN))
    else $error("notification length above eight");

  // A slot beyond the bound entries never notifies
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_NOTIFY) |-> (32'(slot_o) < NUM_BINDS))
    else $error("notification from unbound slot");

endmodule

`default_nettype wire

/* tb/can_rx_id_mask_filter_mailbox_tb.sv */
// Self-checking bench for the CAN acceptance filter with per-entry mailboxes.
// Depends on canflt_pkg and can_rx_id_mask_filter_mailbox; predicts matches,
// mailbox copies and notifications in-line and compares every result in order.
`timescale 1ns / 1ps

module can_rx_id_mask_filter_mailbox_tb;
  import canflt_pkg::*;

  localparam int unsigned NUM_BINDS     = 8;
  localparam int unsigned DRAIN_CYCLES  = 4 * (NUM_BINDS + 3);
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_REQS    = 65;
  localparam int unsigned PHASE_ALL_MAX = 1;
  localparam int unsigned PHASE_ALL_OFF = 4;

  typedef struct {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic [DLC_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [SLOT_W-1:0] rslot;
  } frame_req_t;

  typedef struct {
    kind_e             kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [DLC_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic              last;
  } rx_result_t;

  // DUT stimulus, all known from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [SLOT_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              op_i        = 1'b0;
  logic [ID_W-1:0]   frame_id_i  = '0;
  logic [DLC_W-1:0]  frame_len_i = '0;
  logic [DATA_W-1:0] frame_data_i = '0;
  logic [SLOT_W-1:0] read_slot_i = '0;
  logic              out_stall_i = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic              kind_o;
  logic [SLOT_W-1:0] slot_o;
  logic [ID_W-1:0]   out_id_o;
  logic [DLC_W-1:0]  out_len_o;
  logic [DATA_W-1:0] out_data_o;
  logic              last_o;

  // Shadow state of the filter
  bind_t             bind_shadow [ENTRY_COUNT];
  bind_t             bind_next   [ENTRY_COUNT];
  logic [DATA_W-1:0] mbox_shadow [ENTRY_COUNT];

  frame_req_t        pending_q[$];
  rx_result_t        due_results[$];
  frame_req_t        cur_req;
  rx_result_t        want;

  int unsigned       reqs_queued   = 0;
  int unsigned       reqs_accepted = 0;
  int unsigned       results_seen  = 0;
  int unsigned       settings_used = 0;
  int unsigned       fail_count    = 0;
  int unsigned       gap_left      = 0;
  int unsigned       stall_left    = 0;
  int unsigned       idle_cycles   = 0;
  bit                quiet         = 1'b0;

  can_rx_id_mask_filter_mailbox #(
    .NUM_BINDS(NUM_BINDS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .frame_id_i  (frame_id_i),
    .frame_len_i (frame_len_i),
    .frame_data_i(frame_data_i),
    .read_slot_i (read_slot_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .slot_o      (slot_o),
    .out_id_o    (out_id_o),
    .out_len_o   (out_len_o),
    .out_data_o  (out_data_o),
    .last_o      (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] byte_keep(int unsigned n);
    if (n >= NBYTES) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // Filter one request: update the mailbox copies and queue its results
  task automatic apply_frame(input frame_req_t req);
    rx_result_t        r;
    rx_result_t        held;
    bit                have_held;
    bind_t             b;
    int unsigned       dlc;
    int unsigned       clen;
    int unsigned       n;
    logic [DATA_W-1:0] keep;
    have_held = 1'b0;
    if (req.op == OP_READ) begin
      r = '{KIND_READ, req.rslot, '0, '0, mbox_shadow[req.rslot], 1'b1};
      due_results.push_back(r);
      return;
    end
    dlc = (req.len > NBYTES) ? NBYTES : req.len;
    for (int i = 0; i < NUM_BINDS; i++) begin
      b = bind_shadow[i];
      if (!b.valid || ((req.id ^ b.id) & b.mask) != '0) continue;
      clen = (b.copy_len > NBYTES) ? NBYTES : b.copy_len;
      n    = (clen < dlc) ? clen : dlc;
      keep = byte_keep(n);
      mbox_shadow[i] = (mbox_shadow[i] & ~keep) | (req.data & keep);
      if (b.notify) begin
        // hold each notification until the next one shows it is not the last
        if (have_held) due_results.push_back(held);
        held = '{KIND_NOTIFY, SLOT_W'(i), req.id, DLC_W'(dlc), req.data, 1'b0};
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      due_results.push_back(held);
    end
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Driver: present queued requests, advance on acceptance
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      apply_frame(cur_req);
      reqs_accepted++;
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur_req = pending_q.pop_front();
        op_i         <= cur_req.op;
        frame_id_i   <= cur_req.id;
        frame_len_i  <= cur_req.len;
        frame_data_i <= cur_req.data;
        read_slot_i  <= cur_req.rslot;
        in_valid_i   <= 1'b1;
        gap_left = idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result with nothing predicted: kind %0d slot %0d", kind_o, slot_o);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", DATA_W'(want.kind), DATA_W'(kind_o));
        check_field("slot", DATA_W'(want.slot), DATA_W'(slot_o));
        check_field("out_id", DATA_W'(want.id), DATA_W'(out_id_o));
        check_field("out_len", DATA_W'(want.len), DATA_W'(out_len_o));
        check_field("out_data", want.data, out_data_o);
        check_field("last", DATA_W'(want.last), DATA_W'(last_o));
      end
    end
    // stall the output at random, regardless of what is pending
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic bind_t make_bind(logic v, logic [ID_W-1:0] id, logic [ID_W-1:0] mask,
                                      logic [DLC_W-1:0] len, logic notify);
    bind_t b;
    b = '{notify: notify, copy_len: len, mask: mask, id: id, valid: v};
    return b;
  endfunction

  function automatic bind_t rand_bind();
    logic [ID_W-1:0] mask;
    case ($urandom_range(0, 4))
      0:       mask = '0;
      1:       mask = ID_MASK;
      2:       mask = ID_MASK << $urandom_range(1, 10);
      default: mask = ID_W'($urandom_range(0, 2047));
    endcase
    return make_bind($urandom_range(0, 9) != 0, ID_W'($urandom_range(0, 2047)), mask,
                     DLC_W'($urandom_range(0, 15)), $urandom_range(0, 3) != 0);
  endfunction

  function automatic frame_req_t mk_frame(op_e op, logic [ID_W-1:0] id, logic [DLC_W-1:0] len,
                                          logic [DATA_W-1:0] data, logic [SLOT_W-1:0] rslot);
    frame_req_t f;
    f = '{op, id, len, data, rslot};
    return f;
  endfunction

  // Random request; most receive ids are steered onto a bind entry
  function automatic frame_req_t rand_frame();
    bind_t             b;
    logic [ID_W-1:0]   noise;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    b     = bind_shadow[$urandom_range(0, ENTRY_COUNT - 1)];
    noise = ID_W'($urandom_range(0, 2047));
    id    = ($urandom_range(0, 9) < 6) ? ((b.id & b.mask) | (noise & ~b.mask)) : noise;
    case ($urandom_range(0, 9))
      0:       data = '0;
      1:       data = '1;
      default: data = {$urandom, $urandom};
    endcase
    return mk_frame(($urandom_range(0, 3) == 0) ? OP_READ : OP_RECV, id,
                    DLC_W'($urandom_range(0, 15)), data, SLOT_W'($urandom_range(0, 7)));
  endfunction

  task automatic queue_req(input frame_req_t f);
    pending_q.push_back(f);
    reqs_queued++;
  endtask

  // Program all bind entries back to back from bind_next
  task automatic write_binds();
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= SLOT_W'(i);
      cfg_wdata_i <= bind_next[i];
      bind_shadow[i] = bind_next[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Wait until every request is in and answered, then let silent work finish
  task automatic wait_idle();
    do @(posedge clk_i);
    while (reqs_accepted != reqs_queued || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      bind_shadow[i] = '0;
      mbox_shadow[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset: mailboxes read zero, a receive matches nothing
    for (int i = 0; i < ENTRY_COUNT; i++) queue_req(mk_frame(OP_READ, '0, '0, '0, SLOT_W'(i)));
    queue_req(mk_frame(OP_RECV, ID_MASK, 4'd8, '1, '0));
    wait_idle();

    // Directed entries: exact, catch-all with zero copy, long copy, invalid,
    // silent copy, high-bit mask, every field at maximum, catch-all full copy
    bind_next[0] = make_bind(1'b1, 11'h123, ID_MASK, 4'd8, 1'b1);
    bind_next[1] = make_bind(1'b1, 11'h2AA, 11'h000, 4'd0, 1'b1);
    bind_next[2] = make_bind(1'b1, ID_MASK, ID_MASK, 4'd15, 1'b1);
    bind_next[3] = make_bind(1'b0, 11'h000, 11'h000, 4'd8, 1'b1);
    bind_next[4] = make_bind(1'b1, 11'h000, 11'h000, 4'd3, 1'b0);
    bind_next[5] = make_bind(1'b1, 11'h000, 11'h700, 4'd4, 1'b1);
    bind_next[6] = '1;
    bind_next[7] = make_bind(1'b1, 11'h555, 11'h000, 4'd8, 1'b1);
    write_binds();
    queue_req(mk_frame(OP_RECV, 11'h123, 4'd8, 64'h0123_4567_89AB_CDEF, 3'd0));
    queue_req(mk_frame(OP_RECV, ID_MASK, 4'd15, '1, 3'd7));
    queue_req(mk_frame(OP_RECV, 11'h000, 4'd0, 64'hDEAD_BEEF_CAFE_F00D, 3'd0));
    queue_req(mk_frame(OP_RECV, 11'h0AB, 4'd2, 64'h5A5A_A5A5_0F0F_F0F0, 3'd0));
    queue_req(mk_frame(OP_RECV, 11'h555, 4'd9, 64'h8000_0000_0000_0001, 3'd0));
    for (int i = 0; i < ENTRY_COUNT; i++) queue_req(mk_frame(OP_READ, '0, '0, '0, SLOT_W'(i)));
    wait_idle();

    // Random phases, one with every register at maximum and one all cleared
    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if (p == PHASE_ALL_MAX) bind_next[i] = '1;
        else if (p == PHASE_ALL_OFF) bind_next[i] = '0;
        else bind_next[i] = rand_bind();
      end
      write_binds();
      for (int k = 0; k < PHASE_REQS; k++) queue_req(rand_frame());
      wait_idle();
    end

    $display("covered %0d requests under %0d bind settings", reqs_accepted, settings_used);
    $display("checked %0d results, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
